### src/frs_pkg.sv
// shared types, widths, op codes and defaults for the roulette selector
package frs_pkg;

  // fixed field widths of the channel words
  localparam int OP_W     = 2;
  localparam int FIT_IN_W = 16;
  localparam int FRAC_W   = 16;
  localparam int SEL_W    = 8;
  localparam int TOTAL_W  = 24;
  localparam int AVG_W    = 16;
  localparam int CNT_OUT_W = 9;
  localparam int POP_W    = 9;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
  localparam logic [POP_W-1:0]   POP_RESET   = 9'd256;

  // parameter defaults
  localparam int DEF_MAX_POPULATION = 256;
  localparam int DEF_FITNESS_BITS   = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [FIT_IN_W-1:0] fitness;
    logic [FRAC_W-1:0]   random_fraction;
  } in_word_t;

  typedef struct packed {
    logic [SEL_W-1:0]     selected_index;
    logic [TOTAL_W-1:0]   total_fitness;
    logic [FIT_IN_W-1:0]  best_fitness;
    logic [AVG_W-1:0]     average_fitness;
    logic [CNT_OUT_W-1:0] loaded_count;
    logic                 empty_error;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic walk;
    logic div_init;
    logic div_step;
    logic out_load;
  } frs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_walk;
    logic walk_end;
    logic div_last;
    logic out_free;
  } frs_sts_t;

endpackage

### src/frs_stream_if.sv
// valid/ready channel carrying one word per handshake
interface frs_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/fitness_roulette_selector.sv
// top level of the roulette wheel selector: controller, datapath and channels
// clear, load and no-op words: result registered after execute, divider set-up,
//   24 divider steps and output load
// select: adds the roulette walk over the stored entries, up to the loaded count
// next word accepted the cycle after the result register is loaded; an unread result holds the load
// synchronous active-low reset clears statistics, control and the output valid
module fitness_roulette_selector
  import frs_pkg::*;
#(
  parameter int MAX_POPULATION = DEF_MAX_POPULATION,
  parameter int FITNESS_BITS   = DEF_FITNESS_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  frs_stream_if.sink        in_chan,
  frs_stream_if.source      out_chan,
  input  logic              cfg_we,
  input  logic [POP_W-1:0]  cfg_data
);

  frs_cmd_t  cmd;
  frs_sts_t  sts;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_word;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_word;

  // sequencer
  frs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  frs_datapath #(
    .MAX_POPULATION (MAX_POPULATION),
    .FITNESS_BITS   (FITNESS_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_chan.data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_word  (out_word)
  );

endmodule

### src/frs_ram.sv
// generic simple dual-port ram with registered read
module frs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/frs_ctrl.sv
// sequencer for capture, execute, roulette walk, average division and output
module frs_ctrl
  import frs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  frs_sts_t sts,
  output frs_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_DINIT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_walk ? S_WALK : S_DINIT;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_end) begin
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/frs_datapath.sv
// statistics, fitness store, roulette walk, average divider and output register
module frs_datapath
  import frs_pkg::*;
#(
  parameter int MAX_POPULATION = DEF_MAX_POPULATION,
  parameter int FITNESS_BITS   = DEF_FITNESS_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  frs_cmd_t         cmd,
  output frs_sts_t         sts,
  input  in_word_t         in_word,
  input  logic             cfg_we,
  input  logic [POP_W-1:0] cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word
);

  localparam int IDX_W = $clog2(MAX_POPULATION);
  localparam int CNT_W = $clog2(MAX_POPULATION + 1);
  localparam int SUM_W = (FITNESS_BITS + 1 > TOTAL_W + 1) ? FITNESS_BITS + 1 : TOTAL_W + 1;
  localparam int ACC_W = FITNESS_BITS + CNT_W;
  localparam int TGT_W = FRAC_W + TOTAL_W;
  localparam int CMP_W = (ACC_W + FRAC_W > TGT_W) ? ACC_W + FRAC_W : TGT_W;
  localparam int DIV_STEPS = TOTAL_W;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  // captured word
  logic [OP_W-1:0]         op_r;
  logic [FITNESS_BITS-1:0] fit_r;
  logic [FRAC_W-1:0]       frac_r;

  // statistics and configuration
  logic [TOTAL_W-1:0]      total_r, total_nxt;
  logic [FITNESS_BITS-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [POP_W-1:0]        pop_r;

  // walk
  logic [TGT_W-1:0]        target_r;
  logic [ACC_W-1:0]        acc_r;
  logic [ACC_W-1:0]        acc_sum;
  logic [IDX_W-1:0]        ra_r;
  logic [IDX_W-1:0]        idx_r;
  logic [IDX_W-1:0]        sel_r;
  logic                    err_r;
  logic [CNT_W-1:0]        count_m1;
  logic                    hit;
  logic                    last;

  // divider
  logic [TOTAL_W-1:0]      q_r;
  logic [POP_W-1:0]        rem_r;
  logic [DCNT_W-1:0]       dcnt_r;
  logic [POP_W-1:0]        divisor;
  logic [POP_W:0]          shifted;
  logic [POP_W+1:0]        diff;
  logic                    ge;

  // store
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_raddr;
  logic [FITNESS_BITS-1:0] ram_rdata;
  logic                    not_full;
  logic [SUM_W-1:0]        sum_ext;

  logic                    out_valid_r;
  out_word_t               out_word_r;

  assign not_full = (count_r < CNT_W'(MAX_POPULATION));
  assign ram_we   = cmd.exec && (op_r == OP_LOAD) && not_full;
  assign ram_raddr = cmd.exec ? '0 : ra_r;

  frs_ram #(
    .WIDTH (FITNESS_BITS),
    .DEPTH (MAX_POPULATION)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (fit_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // statistics update on execute
  always_comb begin
    total_nxt = total_r;
    best_nxt  = best_r;
    count_nxt = count_r;
    sum_ext   = SUM_W'(total_r) + SUM_W'(fit_r);
    if (cmd.exec) begin
      case (op_r)
        OP_CLEAR: begin
          total_nxt = '0;
          best_nxt  = '0;
          count_nxt = '0;
        end
        OP_LOAD: begin
          if (not_full) begin
            count_nxt = count_r + CNT_W'(1);
            total_nxt = (sum_ext > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
            if (fit_r > best_r) begin
              best_nxt = fit_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      best_r  <= '0;
      count_r <= '0;
      pop_r   <= POP_RESET;
    end else begin
      total_r <= total_nxt;
      best_r  <= best_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        pop_r <= cfg_data;
      end
    end
  end

  // walk compare: running sum shifted up by the fraction width against fraction times total
  assign count_m1 = count_r - CNT_W'(1);
  assign acc_sum  = acc_r + ACC_W'(ram_rdata);
  assign hit      = (CMP_W'({acc_sum, {FRAC_W{1'b0}}}) >= CMP_W'(target_r));
  assign last     = (CNT_W'(idx_r) == count_m1);

  // captured word, target and walk pointers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_word.op;
      fit_r  <= FITNESS_BITS'(in_word.fitness);
      frac_r <= in_word.random_fraction;
      sel_r  <= '0;
      err_r  <= 1'b0;
    end
    if (cmd.exec) begin
      target_r <= TGT_W'(frac_r) * TGT_W'(total_r);
      acc_r    <= '0;
      ra_r     <= IDX_W'(1);
      idx_r    <= '0;
      if (op_r == OP_SELECT) begin
        err_r <= (count_r == '0);
      end
    end
    if (cmd.walk) begin
      acc_r <= acc_sum;
      idx_r <= ra_r;
      if (CNT_W'(ra_r) < count_m1) begin
        ra_r <= ra_r + IDX_W'(1);
      end
      if (hit || last) begin
        sel_r <= idx_r;
      end
    end
  end

  // restoring divider for the average, one quotient bit a cycle
  assign divisor = (pop_r == '0) ? POP_W'(1) : pop_r;
  assign shifted = {rem_r, q_r[TOTAL_W-1]};
  assign diff    = (POP_W+2)'(shifted) - (POP_W+2)'(divisor);
  assign ge      = !diff[POP_W+1];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      q_r    <= total_r;
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      q_r    <= {q_r[TOTAL_W-2:0], ge};
      rem_r  <= ge ? diff[POP_W-1:0] : shifted[POP_W-1:0];
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r.selected_index  <= SEL_W'(sel_r);
      out_word_r.total_fitness   <= total_r;
      out_word_r.best_fitness    <= FIT_IN_W'(best_r);
      out_word_r.average_fitness <= (|q_r[TOTAL_W-1:AVG_W]) ? {AVG_W{1'b1}} : q_r[AVG_W-1:0];
      out_word_r.loaded_count    <= CNT_OUT_W'(count_r);
      out_word_r.empty_error     <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // status to the controller
  assign sts.need_walk = (op_r == OP_SELECT) && (count_r != '0);
  assign sts.walk_end  = hit || last;
  assign sts.div_last  = (dcnt_r == DCNT_W'(DIV_STEPS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POPULATION))
    else $error("entry count beyond store depth");
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> (CNT_W'(idx_r) < count_r))
    else $error("walk reads past the loaded entries");
  a_best_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(best_r) <= SUM_W'(total_r))
    else $error("best fitness exceeds total");
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result word lost on load");
`endif

endmodule

### sim/fitness_roulette_selector_tb.sv
// testbench for the roulette wheel selector: directed and random words checked against a predictor
`timescale 1ns / 1ps

module fitness_roulette_selector_tb;
  import frs_pkg::*;

  // no-op code, not named in the package
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int STORE_DEPTH = DEF_MAX_POPULATION;
  localparam int DRAIN_CYCLES = 320;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [POP_W-1:0] cfg_data;

  frs_stream_if #(.word_t(in_word_t))  in_chan ();
  frs_stream_if #(.word_t(out_word_t)) out_chan ();

  fitness_roulette_selector dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [FIT_IN_W-1:0] pop_store [STORE_DEPTH];
  logic [TOTAL_W-1:0]  sum_total;
  logic [FIT_IN_W-1:0] top_fitness;
  logic [CNT_OUT_W-1:0] stored_count;
  logic [POP_W-1:0]    avg_divisor;

  out_word_t pending_results [$];
  out_word_t oldest_result;
  int error_count = 0;
  int burst_left = 0;

  // receiver stall pattern state
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;

  // work out the statistics word that one accepted word should produce
  function automatic out_word_t apply_operation(input in_word_t w);
    out_word_t r;
    logic [24:0] grown;
    logic [63:0] slice;
    logic [63:0] acc;
    logic [31:0] quot;
    logic [31:0] div;
    bit found;
    r = '0;
    case (w.op)
      OP_CLEAR: begin
        sum_total = '0;
        top_fitness = '0;
        stored_count = '0;
      end
      OP_LOAD: begin
        if (stored_count < STORE_DEPTH) begin
          pop_store[stored_count] = w.fitness;
          stored_count = stored_count + 1'b1;
          grown = {1'b0, sum_total} + w.fitness;
          sum_total = (grown > TOTAL_MAX) ? TOTAL_MAX : grown[TOTAL_W-1:0];
          if (w.fitness > top_fitness) top_fitness = w.fitness;
        end
      end
      OP_SELECT: begin
        if (stored_count == 0) begin
          r.empty_error = 1'b1;
        end else begin
          slice = 64'(w.random_fraction) * 64'(sum_total);
          acc = '0;
          found = 1'b0;
          for (int i = 0; i < stored_count; i++) begin
            if (!found) begin
              acc = acc + pop_store[i];
              if ((acc << 16) >= slice) begin
                r.selected_index = i[SEL_W-1:0];
                found = 1'b1;
              end
            end
          end
          // fallback to the last entry, not reached since the walk above always ends on a hit
          if (!found) r.selected_index = SEL_W'(stored_count - 1'b1);
        end
      end
      default: ;
    endcase
    div = (avg_divisor == 0) ? 32'd1 : 32'(avg_divisor);
    quot = 32'(sum_total) / div;
    r.total_fitness = sum_total;
    r.best_fitness = top_fitness;
    r.average_fitness = (quot > 32'hFFFF) ? 16'hFFFF : quot[AVG_W-1:0];
    r.loaded_count = stored_count;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %p", $time, out_chan.data);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("selected_index", oldest_result.selected_index,
                    out_chan.data.selected_index);
        check_field("total_fitness", oldest_result.total_fitness,
                    out_chan.data.total_fitness);
        check_field("best_fitness", oldest_result.best_fitness,
                    out_chan.data.best_fitness);
        check_field("average_fitness", oldest_result.average_fitness,
                    out_chan.data.average_fitness);
        check_field("loaded_count", oldest_result.loaded_count,
                    out_chan.data.loaded_count);
        check_field("empty_error", oldest_result.empty_error,
                    out_chan.data.empty_error);
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 400);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: out_chan.ready <= 1'b1;
      1: out_chan.ready <= $urandom_range(0, 1);
      2: out_chan.ready <= ($urandom_range(0, 7) == 0);
      default: out_chan.ready <= ((stall_phase % 8) < 5);
    endcase
  end

  // send one word in bursts with random gaps, predict on acceptance
  task automatic send_word(input logic [OP_W-1:0] op, input logic [FIT_IN_W-1:0] fit,
                           input logic [FRAC_W-1:0] frac);
    in_word_t w;
    int gap;
    w.op = op;
    w.fitness = fit;
    w.random_fraction = frac;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.data <= w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_results.push_back(apply_operation(w));
  endtask

  // stop sending and wait for every expected word
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_population(input logic [POP_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    avg_divisor = value;
  endtask

  function automatic logic [FIT_IN_W-1:0] rand_fitness();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 15);
      3: return $urandom_range(0, 255);
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] rand_fraction();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // empty store after reset, no-op and clear
  task automatic test_after_reset();
    send_word(OP_SELECT, 16'h0000, 16'h8000);
    send_word(OP_NOP, 16'hFFFF, 16'hFFFF);
    send_word(OP_CLEAR, 16'hFFFF, 16'hFFFF);
    send_word(OP_SELECT, 16'hFFFF, 16'h0000);
  endtask

  // field extremes, zero total and the exact slice boundary
  task automatic test_directed();
    send_word(OP_LOAD, 16'h0000, 16'h0000);
    send_word(OP_SELECT, 16'h0000, 16'hFFFF);
    send_word(OP_CLEAR, 16'h0000, 16'h0000);
    send_word(OP_LOAD, 16'h0001, 16'hFFFF);
    send_word(OP_LOAD, 16'h0001, 16'h0000);
    send_word(OP_SELECT, 16'h0000, 16'h8000);
    send_word(OP_SELECT, 16'h0000, 16'h8001);
    send_word(OP_SELECT, 16'hFFFF, 16'hFFFF);
    send_word(OP_SELECT, 16'h0000, 16'h0000);
    send_word(OP_LOAD, 16'hFFFF, 16'h0000);
    send_word(OP_LOAD, 16'hFFFF, 16'h0000);
    send_word(OP_LOAD, 16'h8000, 16'h5555);
    send_word(OP_SELECT, 16'h0000, 16'hAAAA);
    write_population(9'd1);
    send_word(OP_NOP, 16'hFFFF, 16'hFFFF);
    send_word(OP_SELECT, 16'h0000, 16'h7FFF);
    send_word(OP_CLEAR, 16'h0000, 16'h0000);
    send_word(OP_SELECT, 16'h0000, 16'h1234);
  endtask

  // population sizes outside the nominal range
  task automatic test_population_sizes();
    write_population(9'd0);
    send_word(OP_LOAD, 16'hFFFF, 16'h0000);
    send_word(OP_LOAD, 16'h00FF, 16'h0000);
    send_word(OP_NOP, 16'h0000, 16'h0000);
    write_population(9'd511);
    send_word(OP_NOP, 16'h0000, 16'h0000);
    send_word(OP_SELECT, 16'h0000, 16'hC000);
    write_population(9'd256);
    send_word(OP_NOP, 16'h0000, 16'h0000);
  endtask

  // fill the store, load into a full store, then the largest total
  task automatic test_full_store();
    send_word(OP_CLEAR, 16'h0000, 16'h0000);
    for (int i = 0; i < STORE_DEPTH; i++)
      send_word(OP_LOAD, $urandom_range(0, 16'hFFFE), 16'h0000);
    send_word(OP_LOAD, 16'hFFFF, 16'h0000);
    send_word(OP_SELECT, 16'h0000, 16'hFFFF);
    send_word(OP_SELECT, 16'h0000, rand_fraction());
    send_word(OP_CLEAR, 16'h0000, 16'h0000);
    for (int i = 0; i < STORE_DEPTH; i++)
      send_word(OP_LOAD, 16'hFFFF, 16'h0000);
    send_word(OP_SELECT, 16'h0000, 16'hFFFF);
    send_word(OP_SELECT, 16'h0000, 16'h0001);
    send_word(OP_SELECT, 16'h0000, 16'h0000);
  endtask

  // random sequences: mostly clear, loads, selects; some noise
  task automatic test_random(input int budget);
    logic [POP_W-1:0] settings [7];
    int sent;
    int n;
    settings[0] = 9'd1;
    settings[1] = 9'd256;
    settings[2] = $urandom_range(2, 255);
    settings[3] = 9'd0;
    settings[4] = $urandom_range(1, 256);
    settings[5] = 9'd511;
    settings[6] = 9'd256;
    for (int p = 0; p < 7; p++) begin
      write_population(settings[p]);
      sent = 0;
      while (sent < budget / 7) begin
        case ($urandom_range(0, 9))
          7: begin
            send_word($urandom_range(0, 3), $urandom_range(0, 16'hFFFF),
                      $urandom_range(0, 16'hFFFF));
            sent++;
          end
          8: begin
            send_word(OP_CLEAR, $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
            send_word(OP_SELECT, $urandom_range(0, 16'hFFFF), rand_fraction());
            sent += 2;
          end
          9: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
              send_word(OP_LOAD, rand_fitness(), $urandom_range(0, 16'hFFFF));
            send_word(OP_SELECT, $urandom_range(0, 16'hFFFF), rand_fraction());
            sent += n + 1;
          end
          default: begin
            // well-formed: clear, a batch of loads, several selects
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 256) : $urandom_range(1, 16);
            send_word(OP_CLEAR, $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
            for (int i = 0; i < n; i++)
              send_word(OP_LOAD, rand_fitness(), $urandom_range(0, 16'hFFFF));
            for (int i = 0; i < $urandom_range(1, 6); i++) begin
              send_word(OP_SELECT, $urandom_range(0, 16'hFFFF), rand_fraction());
              sent++;
            end
            sent += n + 1;
          end
        endcase
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    sum_total = '0;
    top_fitness = '0;
    stored_count = '0;
    avg_divisor = POP_RESET;
    for (int i = 0; i < STORE_DEPTH; i++) pop_store[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_directed();
    test_population_sizes();
    test_full_store();
    test_random(1200);

    // let the last words drain, then watch for stray results
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** fitness_roulette_selector: PASSED **");
    end else begin
      $display("** fitness_roulette_selector: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("%0t: timeout", $time);
    $display("** fitness_roulette_selector: FAILED **");
    $finish;
  end

endmodule

### sim.f
src/frs_pkg.sv
src/frs_stream_if.sv
src/frs_ram.sv
src/frs_ctrl.sv
src/frs_datapath.sv
src/fitness_roulette_selector.sv
sim/fitness_roulette_selector_tb.sv
